// ===== design/bbc_pkg.sv =====
// Shared constants, command and status types, and size helpers for the blob centroid block.
package bbc_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_SIZE_W  = 13;
    localparam int CFG_THR_W   = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_CENT_W  = 20;
    localparam int OUT_CNT_W   = 25;

    localparam int CFG_SIZE_MAX = 2 ** CFG_SIZE_W - 1;

    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;
    localparam int DEF_FRACTION_BITS = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd2;

    localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_WIDTH     = 13'd640;
    localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_HEIGHT    = 13'd480;
    localparam logic [CFG_THR_W-1:0]  RST_LEVEL_THRESHOLD = 8'd100;

    typedef struct packed {
        logic accept;
        logic start;
        logic step;
        logic load;
    } bbc_cmd_t;

    typedef struct packed {
        logic last_pos;
    } bbc_status_t;

    // Largest frame dimension the block can actually see, given the register width.
    function automatic int eff_size(input int max_v);
        return (max_v < CFG_SIZE_MAX) ? max_v : CFG_SIZE_MAX;
    endfunction

    function automatic int pos_width(input int max_v);
        return $clog2(eff_size(max_v));
    endfunction

    function automatic int cnt_width(input int max_w, input int max_h);
        return $clog2(eff_size(max_w) * eff_size(max_h) + 1);
    endfunction

    function automatic int div_width(input int max_w, input int max_h, input int frac);
        int pw;
        pw = (pos_width(max_w) > pos_width(max_h)) ? pos_width(max_w) : pos_width(max_h);
        return cnt_width(max_w, max_h) + pw + frac;
    endfunction

endpackage

// ===== design/bbc_div_lane.sv =====
// One restoring divider lane that yields one quotient bit per cycle while step is high.
module bbc_div_lane
    import bbc_pkg::*;
#(
    parameter int DW    = 45,
    parameter int CNT_W = 25
)
(
    input  logic                  clk,
    input  logic                  load,
    input  logic                  step,
    input  logic [DW-1:0]         dividend,
    input  logic [CNT_W-1:0]      divisor,
    output logic [OUT_CENT_W-1:0] quotient
);

    logic [DW-1:0]         dividend_reg, dividend_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [OUT_CENT_W-1:0] quot_reg, quot_next;
    logic [CNT_W:0]        rem_shift;
    logic [CNT_W:0]        rem_sub;
    logic                  ge;

    always_comb
    begin
        rem_shift = {rem_reg, dividend_reg[DW-1]};
        ge        = rem_shift >= {1'b0, divisor};
        rem_sub   = rem_shift - {1'b0, divisor};

        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        if (load)
        begin
            dividend_next = dividend;
            rem_next      = '0;
            quot_next     = '0;
        end
        else if (step)
        begin
            dividend_next = dividend_reg << 1;
            rem_next      = ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            // Only the low quotient bits survive, which matches the masked result.
            quot_next     = {quot_reg[OUT_CENT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
    end

    assign quotient = quot_reg;

endmodule

// ===== design/bbc_datapath.sv =====
// Datapath: configuration registers, raster counters, moment sums, dividers and result register.
module bbc_datapath
    import bbc_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [PIX_W-1:0]      pixel_value,
    input  bbc_cmd_t              cmd,
    output bbc_status_t           status,
    output logic [OUT_CENT_W-1:0] centroid_x,
    output logic [OUT_CENT_W-1:0] centroid_y,
    output logic [OUT_CNT_W-1:0]  object_count,
    output logic                  frame_empty
);

    localparam int XW  = pos_width(MAX_WIDTH);
    localparam int YW  = pos_width(MAX_HEIGHT);
    localparam int CW  = cnt_width(MAX_WIDTH, MAX_HEIGHT);
    localparam int SXW = CW + XW;
    localparam int SYW = CW + YW;
    localparam int DW  = div_width(MAX_WIDTH, MAX_HEIGHT, FRACTION_BITS);

    localparam logic [CFG_SIZE_W-1:0] W_LIMIT = CFG_SIZE_W'(eff_size(MAX_WIDTH));
    localparam logic [CFG_SIZE_W-1:0] H_LIMIT = CFG_SIZE_W'(eff_size(MAX_HEIGHT));

    logic [CFG_SIZE_W-1:0] width_reg, width_next;
    logic [CFG_SIZE_W-1:0] height_reg, height_next;
    logic [CFG_THR_W-1:0]  thresh_reg, thresh_next;

    logic [XW-1:0]  col_reg, col_next;
    logic [YW-1:0]  row_reg, row_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [SXW-1:0] csum_reg, csum_next;
    logic [SYW-1:0] rsum_reg, rsum_next;

    logic [CW-1:0]  divisor_reg, divisor_next;
    logic           empty_reg, empty_next;

    logic [OUT_CENT_W-1:0] cx_reg, cx_next;
    logic [OUT_CENT_W-1:0] cy_reg, cy_next;
    logic [OUT_CNT_W-1:0]  count_reg, count_next;
    logic                  fempty_reg, fempty_next;

    logic [CFG_SIZE_W-1:0] eff_w_full, eff_h_full;
    logic [XW:0]           eff_w;
    logic [YW:0]           eff_h;
    logic [XW:0]           col_inc;
    logic [YW:0]           row_inc;
    logic                  row_end;
    logic                  last_pos;
    logic                  hit;
    logic [CW-1:0]         cnt_inc;
    logic [SXW-1:0]        csum_inc;
    logic [SYW-1:0]        rsum_inc;
    logic [DW-1:0]         dividend_x, dividend_y;
    logic [OUT_CENT_W-1:0] quot_x, quot_y;

    // Frame size as used: zero acts as one, large values stop at the maximum.
    always_comb
    begin
        priority if (width_reg == '0)
            eff_w_full = CFG_SIZE_W'(1);
        else if (width_reg > W_LIMIT)
            eff_w_full = W_LIMIT;
        else
            eff_w_full = width_reg;

        priority if (height_reg == '0)
            eff_h_full = CFG_SIZE_W'(1);
        else if (height_reg > H_LIMIT)
            eff_h_full = H_LIMIT;
        else
            eff_h_full = height_reg;
    end

    assign eff_w    = (XW+1)'(eff_w_full);
    assign eff_h    = (YW+1)'(eff_h_full);
    assign col_inc  = {1'b0, col_reg} + (XW+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (YW+1)'(1);
    assign row_end  = col_inc >= eff_w;
    assign last_pos = row_end && (row_inc >= eff_h);

    assign status.last_pos = last_pos;

    assign hit      = pixel_value <= thresh_reg;
    assign cnt_inc  = cnt_reg + CW'(hit);
    assign csum_inc = csum_reg + (hit ? SXW'(col_reg) : '0);
    assign rsum_inc = rsum_reg + (hit ? SYW'(row_reg) : '0);

    assign dividend_x = DW'(csum_inc) << FRACTION_BITS;
    assign dividend_y = DW'(rsum_inc) << FRACTION_BITS;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        thresh_next = thresh_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:     width_next  = cfg_data[CFG_SIZE_W-1:0];
                REG_IMAGE_HEIGHT:    height_next = cfg_data[CFG_SIZE_W-1:0];
                REG_LEVEL_THRESHOLD: thresh_next = cfg_data[CFG_THR_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        cnt_next  = cnt_reg;
        csum_next = csum_reg;
        rsum_next = rsum_reg;
        if (cmd.accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_pos ? '0 : row_inc[YW-1:0];
            end
            else
            begin
                col_next = col_inc[XW-1:0];
            end

            // The frame's sums move into the dividers and the accumulators start over.
            if (last_pos)
            begin
                cnt_next  = '0;
                csum_next = '0;
                rsum_next = '0;
            end
            else
            begin
                cnt_next  = cnt_inc;
                csum_next = csum_inc;
                rsum_next = rsum_inc;
            end
        end
    end

    always_comb
    begin
        divisor_next = divisor_reg;
        empty_next   = empty_reg;
        if (cmd.start)
        begin
            divisor_next = cnt_inc;
            empty_next   = cnt_inc == '0;
        end
    end

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        count_next  = count_reg;
        fempty_next = fempty_reg;
        if (cmd.load)
        begin
            cx_next     = empty_reg ? '0 : quot_x;
            cy_next     = empty_reg ? '0 : quot_y;
            count_next  = OUT_CNT_W'(divisor_reg);
            fempty_next = empty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            thresh_reg <= RST_LEVEL_THRESHOLD;
            col_reg    <= '0;
            row_reg    <= '0;
            cnt_reg    <= '0;
            csum_reg   <= '0;
            rsum_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            thresh_reg <= thresh_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cnt_reg    <= cnt_next;
            csum_reg   <= csum_next;
            rsum_reg   <= rsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        empty_reg   <= empty_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        count_reg   <= count_next;
        fempty_reg  <= fempty_next;
    end

    bbc_div_lane #(
        .DW    (DW),
        .CNT_W (CW)
    ) u_div_x (
        .clk      (clk),
        .load     (cmd.start),
        .step     (cmd.step),
        .dividend (dividend_x),
        .divisor  (divisor_reg),
        .quotient (quot_x)
    );

    bbc_div_lane #(
        .DW    (DW),
        .CNT_W (CW)
    ) u_div_y (
        .clk      (clk),
        .load     (cmd.start),
        .step     (cmd.step),
        .dividend (dividend_y),
        .divisor  (divisor_reg),
        .quotient (quot_y)
    );

    assign centroid_x   = cx_reg;
    assign centroid_y   = cy_reg;
    assign object_count = count_reg;
    assign frame_empty  = fempty_reg;

endmodule

// ===== design/bbc_ctrl.sv =====
// Controller: pixel handshake, divider sequencing and result word handshake.
module bbc_ctrl
    import bbc_pkg::*;
#(
    parameter int DIV_STEPS = 45
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    output logic        result_valid,
    input  logic        result_stall,
    input  bbc_status_t status,
    output bbc_cmd_t    cmd
);

    localparam int SW = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] step_cnt_reg, step_cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept;
    logic          load_ok;

    // Only the last pixel of a frame has to wait for the divider and result register.
    assign pixel_stall = status.last_pos && (state_reg != S_IDLE);
    assign accept      = pixel_valid && !pixel_stall;
    assign load_ok     = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd.accept     = accept;
        cmd.start      = 1'b0;
        cmd.step       = 1'b0;
        cmd.load       = 1'b0;

        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && status.last_pos)
                begin
                    cmd.start     = 1'b1;
                    step_cnt_next = SW'(DIV_STEPS);
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step      = 1'b1;
                step_cnt_next = step_cnt_reg - SW'(1);
                if (step_cnt_reg == SW'(1))
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (load_ok)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// ===== design/binary_blob_centroid.sv =====
// Top level of the binary blob centroid block: controller plus datapath.
//
//  Channel   Direction  Handshake                   Word
//  pixel     in         pixel_valid / pixel_stall   pixel_value
//  result    out        result_valid / result_stall centroid_x, centroid_y, object_count,
//                                                   frame_empty
//  config    in         cfg_we                      cfg_index, cfg_data
//
// Pixels are taken one per cycle. The last pixel of a frame starts both centroid
// divisions, which run side by side at one quotient bit per cycle for DIV_STEPS steps
// (45 with the default sizes); then the result register loads once result_stall allows.
// Pixels of the next frame keep flowing meanwhile; only its last pixel stalls while the
// division runs or an earlier result word is still held by result_stall.
// Reset clears counters and sums and restores the default frame size and threshold.
module binary_blob_centroid
    import bbc_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIX_W-1:0]      pixel_value,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [OUT_CENT_W-1:0] centroid_x,
    output logic [OUT_CENT_W-1:0] centroid_y,
    output logic [OUT_CNT_W-1:0]  object_count,
    output logic                  frame_empty
);

    localparam int DIV_STEPS = div_width(MAX_WIDTH, MAX_HEIGHT, FRACTION_BITS);

    bbc_cmd_t    cmd;
    bbc_status_t status;

    bbc_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    bbc_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_value  (pixel_value),
        .cmd          (cmd),
        .status       (status),
        .centroid_x   (centroid_x),
        .centroid_y   (centroid_y),
        .object_count (object_count),
        .frame_empty  (frame_empty)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for binary_blob_centroid: directed frames, then random frames.
module tb;
    import bbc_pkg::*;

    localparam int FRAME_MAX_W     = DEF_MAX_WIDTH;
    localparam int FRAME_MAX_H     = DEF_MAX_HEIGHT;
    localparam int FRAC_BITS       = DEF_FRACTION_BITS;
    localparam int DRAIN_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PIXELS   = 550;
    localparam int RANDOM_FRAMES   = 30;

    // Index 3 decodes to no register.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OUT_CENT_W-1:0] x;
        logic [OUT_CENT_W-1:0] y;
        logic [OUT_CNT_W-1:0]  count;
        logic                  empty;
    } centroid_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pixel_valid;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      pixel_value;
    logic                  result_valid;
    logic                  result_stall;
    logic [OUT_CENT_W-1:0] centroid_x;
    logic [OUT_CENT_W-1:0] centroid_y;
    logic [OUT_CNT_W-1:0]  object_count;
    logic                  frame_empty;

    // Frame accumulator mirror and register copies.
    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;
    logic [CFG_THR_W-1:0]  thr_reg;
    int unsigned           col_pos;
    int unsigned           row_pos;
    longint unsigned       obj_total;
    longint unsigned       col_sum;
    longint unsigned       row_sum;

    centroid_t pending_centroids[$];
    int        pixels_sent;
    int        frames_closed;
    int        errors;
    bit        pixel_paced;
    bit        drain_paced;

    binary_blob_centroid uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .centroid_x   (centroid_x),
        .centroid_y   (centroid_y),
        .object_count (object_count),
        .frame_empty  (frame_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int v;
        if ($urandom_range(0, 1) == 0)
            return PIX_W'($urandom_range(0, 255));
        // Cluster around the threshold so both sides of the compare are hit.
        v = int'(thr_reg) + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[PIX_W-1:0];
    endfunction

    task automatic accumulate_pixel(input logic [PIX_W-1:0] v);
        int unsigned     w;
        int unsigned     h;
        bit              frame_done;
        centroid_t       res;
        longint unsigned mean;
        w = clamp_dim(width_reg, FRAME_MAX_W);
        h = clamp_dim(height_reg, FRAME_MAX_H);
        frame_done = 1'b0;
        if (v <= thr_reg)
        begin
            obj_total++;
            col_sum += col_pos;
            row_sum += row_pos;
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h)
            begin
                frame_done = 1'b1;
                row_pos = 0;
            end
            else
                row_pos++;
        end
        else
            col_pos++;
        if (frame_done)
        begin
            res = '0;
            if (obj_total == 0)
                res.empty = 1'b1;
            else
            begin
                mean = (col_sum << FRAC_BITS) / obj_total;
                res.x = mean[OUT_CENT_W-1:0];
                mean = (row_sum << FRAC_BITS) / obj_total;
                res.y = mean[OUT_CENT_W-1:0];
                res.count = obj_total[OUT_CNT_W-1:0];
            end
            pending_centroids.push_back(res);
            frames_closed++;
            obj_total = 0;
            col_sum = 0;
            row_sum = 0;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] v);
        int gap;
        gap = pixel_paced ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_value <= v;
        do @(posedge clk); while (pixel_stall !== 1'b0);
        accumulate_pixel(v);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:     width_reg = data[CFG_SIZE_W-1:0];
            REG_IMAGE_HEIGHT:    height_reg = data[CFG_SIZE_W-1:0];
            REG_LEVEL_THRESHOLD: thr_reg = data[CFG_THR_W-1:0];
            default:             ;
        endcase
    endtask

    // Let every pending result drain, then give the pixel pipe time to go quiet.
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (pending_centroids.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Result side: after each word, hold stall for a drawn number of cycles of the next word.
    initial
    begin : result_check
        int        hold;
        centroid_t want;
        hold = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_stall === 1'b0)
            begin
                if (pending_centroids.size() == 0)
                begin
                    $error("result word with no frame pending");
                    errors++;
                end
                else
                begin
                    want = pending_centroids.pop_front();
                    check_field("centroid_x", 32'(want.x), 32'(centroid_x));
                    check_field("centroid_y", 32'(want.y), 32'(centroid_y));
                    check_field("object_count", 32'(want.count), 32'(object_count));
                    check_field("frame_empty", 32'(want.empty), 32'(frame_empty));
                end
                hold = drain_paced ? $urandom_range(0, 16) : 0;
            end
            else if (result_valid === 1'b1 && hold > 0)
                hold--;
            result_stall <= (hold > 0);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid === 1'b1 && pixel_stall === 1'b0)
                || (result_valid === 1'b1 && result_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("[binary_blob_centroid] ERROR");
        $finish;
    end

    // Reset values are used for a few pixels, then the frame is cut short mid-row.
    task automatic test_default_setup();
        send_pixel(8'd99);
        send_pixel(8'd100);
        send_pixel(8'd101);
        send_pixel(8'd255);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd5);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        send_pixel(8'd0);
        wait_idle();
    endtask

    task automatic test_threshold_edges();
        write_reg(REG_IMAGE_WIDTH, 13'd4);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        write_reg(REG_LEVEL_THRESHOLD, 13'd0);
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd0);
        send_pixel(8'd127);
        send_pixel(8'd0);
        wait_idle();
        write_reg(REG_LEVEL_THRESHOLD, 13'd255);
        repeat (8) send_pixel(PIX_W'($urandom_range(0, 255)));
        wait_idle();
        write_reg(REG_LEVEL_THRESHOLD, 13'd128);
        repeat (2)
        begin
            send_pixel(8'd127);
            send_pixel(8'd128);
            send_pixel(8'd129);
            send_pixel(8'd255);
        end
        wait_idle();
    endtask

    task automatic test_empty_and_decode();
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        // Upper data bits must be dropped, leaving a threshold of zero.
        write_reg(REG_LEVEL_THRESHOLD, 13'h1F00);
        write_reg(REG_UNUSED, 13'h1FFF);
        repeat (6) send_pixel(PIX_W'($urandom_range(1, 255)));
        repeat (5) send_pixel(8'd255);
        send_pixel(8'd0);
        wait_idle();
    endtask

    task automatic test_size_clamp();
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        write_reg(REG_LEVEL_THRESHOLD, 13'd0);
        send_pixel(8'd0);
        send_pixel(8'd200);
        send_pixel(8'd0);
        wait_idle();
        // Oversized sizes clamp to the maximum, so a short run must not end a row or frame.
        write_reg(REG_IMAGE_WIDTH, 13'h1002);
        write_reg(REG_IMAGE_HEIGHT, 13'h1001);
        repeat (3)
        begin
            send_pixel(8'd0);
            send_pixel(8'd255);
        end
        wait_idle();
        // Shrinking the frame makes the next pixel end the row; the row after it closes the frame.
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        write_reg(REG_LEVEL_THRESHOLD, 13'd255);
        repeat (5) send_pixel(PIX_W'($urandom_range(0, 255)));
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        send_pixel(PIX_W'($urandom_range(0, 255)));
        wait_idle();
    endtask

    task automatic test_resize_mid_frame();
        write_reg(REG_IMAGE_WIDTH, 13'd8);
        write_reg(REG_IMAGE_HEIGHT, 13'd4);
        write_reg(REG_LEVEL_THRESHOLD, 13'd127);
        repeat (13) send_pixel(pick_pixel());
        wait_idle();
        // The column already lies past the new width, on the last row; the next pixel closes the frame.
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        repeat (7) send_pixel(pick_pixel());
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        repeat (12) send_pixel(pick_pixel());
        wait_idle();
    endtask

    task automatic test_random_frames();
        int          pixel_goal;
        int          frame_goal;
        int unsigned frame_len;
        int unsigned n;
        pixel_goal = pixels_sent + RANDOM_PIXELS;
        frame_goal = frames_closed + RANDOM_FRAMES;
        while (pixels_sent < pixel_goal || frames_closed < frame_goal)
        begin
            wait_idle();
            pixel_paced = ($urandom_range(0, 3) != 0);
            drain_paced = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_IMAGE_WIDTH,
                          CFG_DATA_W'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 8)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_IMAGE_HEIGHT,
                          CFG_DATA_W'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6)));
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_LEVEL_THRESHOLD, 13'd0);
                    1:       write_reg(REG_LEVEL_THRESHOLD, 13'd255);
                    default: write_reg(REG_LEVEL_THRESHOLD,
                                       CFG_DATA_W'($urandom_range(0, 13'h1FFF)));
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 13'h1FFF)));
            frame_len = clamp_dim(width_reg, FRAME_MAX_W) * clamp_dim(height_reg, FRAME_MAX_H);
            n = frame_len * $urandom_range(1, 3);
            // Now and then leave a frame unfinished across the next register update.
            if (frame_len > 1 && $urandom_range(0, 2) == 0)
                n += $urandom_range(1, frame_len - 1);
            repeat (n) send_pixel(pick_pixel());
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_IMAGE_WIDTH;
        cfg_data    = '0;
        pixel_valid = 1'b0;
        pixel_value = '0;
        pixel_paced = 1'b1;
        drain_paced = 1'b1;
        width_reg   = RST_IMAGE_WIDTH;
        height_reg  = RST_IMAGE_HEIGHT;
        thr_reg     = RST_LEVEL_THRESHOLD;
        col_pos     = 0;
        row_pos     = 0;
        obj_total   = 0;
        col_sum     = 0;
        row_sum     = 0;
        pixels_sent = 0;
        frames_closed = 0;
        errors      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_default_setup();
        test_threshold_edges();
        test_empty_and_decode();
        test_size_clamp();
        test_resize_mid_frame();
        test_random_frames();
        if (errors == 0)
            $display("[binary_blob_centroid] OK");
        else
            $display("[binary_blob_centroid] ERROR");
        $finish;
    end

endmodule
